@@ rtl/core/pid_heater_controller_defines.svh @@
// Assertion macros shared by the heater PID controller RTL.
`ifndef PID_HEATER_CONTROLLER_DEFINES_SVH
`define PID_HEATER_CONTROLLER_DEFINES_SVH
`ifndef SYNTHESIS
`define PHC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define PHC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);
`else
`define PHC_ASSERT(label, prop, msg)
`define PHC_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

@@ rtl/core/phc_pkg.sv @@
// Types and constants of the heater PID controller.
`default_nettype none
package phc_pkg;
   localparam int IntegralLimit = 640000;
   localparam int DeadZone      = 0;
   localparam int FiltOne       = 65536;

   localparam logic signed [15:0] SetpointReset = 16'sd11520;
   localparam logic [31:0] KpReset     = 32'd262144000;
   localparam logic [31:0] KiReset     = 32'd124518;
   localparam logic [31:0] KdReset     = 32'd655360;
   localparam logic [14:0] LowReset    = 15'd384;
   localparam logic [14:0] HighReset   = 15'd768;
   localparam logic [16:0] FiltReset   = 17'd3277;
   localparam logic [14:0] OutLimReset = 15'd9600;

   typedef enum logic [2:0] {
      CSR_SETPOINT, CSR_KP, CSR_KI, CSR_KD,
      CSR_INTEG_FULL_BELOW, CSR_INTEG_STOP_ABOVE, CSR_DERIV_FILTER, CSR_OUT_LIMIT
   } csr_index_type;

   typedef enum logic [1:0] {BAND_FULL, BAND_MID, BAND_STOP} band_type;

   typedef enum logic [2:0] {
      MUL_NONE, MUL_WGT, MUL_P, MUL_I, MUL_D, MUL_FHI, MUL_FLO
   } mul_op_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_AVG, ST_WMUL, ST_DIVLD, ST_DIVRUN, ST_INTEG, ST_PMUL, ST_IMUL,
      ST_DMUL, ST_DMLD, ST_FX, ST_FHI, ST_FLO, ST_FUPD, ST_SUM, ST_OUT
   } phc_state_type;

   typedef struct packed {
      logic       capture;
      logic       avg_ld;
      mul_op_type mul_op;
      logic       div_start;
      logic       integ_ld;
      logic       acc_p;
      logic       acc_i;
      logic       dm_ld;
      logic       x_ld;
      logic       hi_ld;
      logic       fd_ld;
      logic       t_ld;
      logic       out_ld;
   } phc_cmd_type;

   typedef struct packed {
      band_type band;
      logic     div_busy;
      logic     out_free;
   } phc_status_type;
endpackage
`default_nettype wire

@@ rtl/core/phc_req_if.sv @@
// Sample channel: valid/ready transfer of one temperature.
`default_nettype none
interface phc_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] temperature;
   modport source (output valid, output temperature, input ready);
   modport sink (input valid, input temperature, output ready);
endinterface
`default_nettype wire

@@ rtl/core/phc_rsp_if.sv @@
// Result channel: valid/ready transfer of one PWM compare value.
`default_nettype none
interface phc_rsp_if;
   logic        valid;
   logic        ready;
   logic [14:0] pwm_compare;
   modport source (output valid, output pwm_compare, input ready);
   modport sink (input valid, input pwm_compare, output ready);
endinterface
`default_nettype wire

@@ rtl/core/phc_div.sv @@
// Restoring divider, one quotient bit per cycle, for the integral weight.
`default_nettype none
module phc_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [30:0] dividend,
   input  logic [14:0] divisor,
   output logic        busy,
   output logic [30:0] quotient
);
   localparam int DivSteps = 31;
   localparam int CntW     = $clog2(DivSteps);

   logic [14:0]     rem_ff, rem_in;
   logic [30:0]     quo_ff, quo_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            busy_ff, busy_in;
   logic [15:0]     trial;
   logic [15:0]     diff;
   logic            ge;

   always_comb begin
      trial   = {rem_ff, quo_ff[30]};
      ge      = trial >= {1'b0, divisor};
      diff    = trial - {1'b0, divisor};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[14:0] : trial[14:0];
         quo_in = {quo_ff[29:0], ge};
         cnt_in = cnt_ff + CntW'(1);
         if (cnt_ff == CntW'(DivSteps - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
      end
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;
endmodule
`default_nettype wire

@@ rtl/core/phc_ctrl.sv @@
// Sequencer of the heater PID controller: one sample at a time.
`default_nettype none
`include "pid_heater_controller_defines.svh"
module phc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output phc_pkg::phc_cmd_type    cmd,
   input  phc_pkg::phc_status_type status
);
   import phc_pkg::*;

   phc_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_AVG;
         ST_AVG:    state_in = (status.band == BAND_MID) ? ST_WMUL : ST_INTEG;
         ST_WMUL:   state_in = ST_DIVLD;
         ST_DIVLD:  state_in = ST_DIVRUN;
         ST_DIVRUN: if (!status.div_busy) state_in = ST_INTEG;
         ST_INTEG:  state_in = ST_PMUL;
         ST_PMUL:   state_in = ST_IMUL;
         ST_IMUL:   state_in = ST_DMUL;
         ST_DMUL:   state_in = ST_DMLD;
         ST_DMLD:   state_in = ST_FX;
         ST_FX:     state_in = ST_FHI;
         ST_FHI:    state_in = ST_FLO;
         ST_FLO:    state_in = ST_FUPD;
         ST_FUPD:   state_in = ST_SUM;
         ST_SUM:    state_in = ST_OUT;
         ST_OUT:    if (status.out_free) state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      cmd.mul_op = MUL_NONE;
      req_ready  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_AVG:    cmd.avg_ld = 1'b1;
         ST_WMUL:   cmd.mul_op = MUL_WGT;
         ST_DIVLD:  cmd.div_start = 1'b1;
         ST_DIVRUN: cmd.mul_op = MUL_NONE;
         ST_INTEG:  cmd.integ_ld = 1'b1;
         ST_PMUL:   cmd.mul_op = MUL_P;
         ST_IMUL: begin
            cmd.mul_op = MUL_I;
            cmd.acc_p  = 1'b1;
         end
         ST_DMUL: begin
            cmd.mul_op = MUL_D;
            cmd.acc_i  = 1'b1;
         end
         ST_DMLD:   cmd.dm_ld = 1'b1;
         ST_FX:     cmd.x_ld = 1'b1;
         ST_FHI:    cmd.mul_op = MUL_FHI;
         ST_FLO: begin
            cmd.mul_op = MUL_FLO;
            cmd.hi_ld  = 1'b1;
         end
         ST_FUPD:   cmd.fd_ld = 1'b1;
         ST_SUM:    cmd.t_ld = 1'b1;
         ST_OUT:    cmd.out_ld = status.out_free;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `PHC_ASSERT_NEXT(a_capture_holds_off, cmd.capture, !req_ready, "sample taken while busy")
   `PHC_ASSERT_NEXT(a_div_starts, cmd.div_start, status.div_busy, "divider did not start")
   `PHC_ASSERT(a_idle_div_quiet, req_ready |-> !status.div_busy, "divider busy while idle")
endmodule
`default_nettype wire

@@ rtl/core/phc_datapath.sv @@
// Datapath: registers, shared multiplier, integral, filter and output stage.
`default_nettype none
`include "pid_heater_controller_defines.svh"
module phc_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write_en,
   input  logic [2:0]              csr_index,
   input  logic [31:0]             csr_write_data,
   input  logic signed [15:0]      temperature,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output logic [14:0]             pwm_compare,
   input  phc_pkg::phc_cmd_type    cmd,
   output phc_pkg::phc_status_type status
);
   import phc_pkg::*;

   localparam logic signed [21:0] LimS = 22'(IntegralLimit);

   // configuration
   logic signed [15:0] setpoint_ff, setpoint_in;
   logic [31:0] kp_ff, kp_in, ki_ff, ki_in, kd_ff, kd_in;
   logic [14:0] low_ff, low_in, high_ff, high_in, olim_ff, olim_in;
   logic [16:0] filt_ff, filt_in;

   // loop state
   logic signed [16:0] prior_ff, prior_in;
   logic signed [20:0] integ_ff, integ_in;
   logic signed [47:0] fd_ff, fd_in;
   logic [14:0]        now_ff, now_in, before_ff, before_in;

   // per-sample work registers
   logic signed [16:0] e_ff, e_in;
   logic [15:0]        mag_ff, mag_in;
   logic signed [16:0] avg_ff, avg_in;
   logic [64:0]        prod_ff;
   logic signed [49:0] acc_ff, acc_in;
   logic signed [47:0] dm_ff, dm_in;
   logic [48:0]        xmag_ff, xmag_in;
   logic               xneg_ff, xneg_in;
   logic [49:0]        hi_ff, hi_in;
   logic signed [50:0] t_ff, t_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [14:0]        pwm_ff, pwm_in;

   logic signed [16:0] e_raw, e_neg;
   logic signed [17:0] sum2;
   logic signed [16:0] avg_neg;
   logic [15:0]        avg_mag;
   band_type           band;
   logic [32:0]        mul_a;
   logic [31:0]        mul_b;
   logic [64:0]        mul_prod;
   logic [14:0]        wgt;
   logic signed [20:0] integ_neg;
   logic signed [15:0] diff, diff_neg;
   logic [16:0]        f_eff;
   logic [49:0]        pm50, im50;
   logic [47:0]        d48;
   logic signed [48:0] x49;
   logic [49:0]        r50;
   logic [16:0]        q17;
   logic signed [16:0] inc;
   logic signed [21:0] s22;
   logic signed [50:0] lim51;
   logic               div_busy;
   logic [30:0]        div_quo;

   always_comb begin
      setpoint_in = setpoint_ff;
      kp_in       = kp_ff;
      ki_in       = ki_ff;
      kd_in       = kd_ff;
      low_in      = low_ff;
      high_in     = high_ff;
      filt_in     = filt_ff;
      olim_in     = olim_ff;
      if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_SETPOINT:         setpoint_in = csr_write_data[15:0];
            CSR_KP:               kp_in = csr_write_data;
            CSR_KI:               ki_in = csr_write_data;
            CSR_KD:               kd_in = csr_write_data;
            CSR_INTEG_FULL_BELOW: low_in = csr_write_data[14:0];
            CSR_INTEG_STOP_ABOVE: high_in = csr_write_data[14:0];
            CSR_DERIV_FILTER:     filt_in = csr_write_data[16:0];
            CSR_OUT_LIMIT:        olim_in = csr_write_data[14:0];
         endcase
      end
   end

   // error and band
   always_comb begin
      e_raw   = {setpoint_ff[15], setpoint_ff} - {temperature[15], temperature};
      e_neg   = -e_raw;
      e_in    = e_ff;
      mag_in  = mag_ff;
      if (cmd.capture) begin
         e_in   = e_raw;
         mag_in = e_raw[16] ? e_neg[15:0] : e_raw[15:0];
         if ({1'b0, mag_in} < 17'(DeadZone)) begin
            e_in   = '0;
            mag_in = '0;
         end
      end
      sum2    = {e_ff[16], e_ff} + {prior_ff[16], prior_ff};
      avg_in  = cmd.avg_ld ? sum2[17:1] : avg_ff;
      avg_neg = -avg_ff;
      avg_mag = avg_ff[16] ? avg_neg[15:0] : avg_ff[15:0];
      if (mag_ff < {1'b0, low_ff}) begin
         band = BAND_FULL;
      end else if (mag_ff < {1'b0, high_ff}) begin
         band = BAND_MID;
      end else begin
         band = BAND_STOP;
      end
   end

   // shared multiplier
   always_comb begin
      wgt       = high_ff - mag_ff[14:0];
      integ_neg = -integ_ff;
      diff      = {1'b0, now_ff} - {1'b0, before_ff};
      diff_neg  = -diff;
      f_eff     = (filt_ff > 17'(FiltOne)) ? 17'(FiltOne) : filt_ff;
      mul_a     = '0;
      mul_b     = '0;
      unique case (cmd.mul_op)
         MUL_NONE: mul_a = '0;
         MUL_WGT: begin
            mul_a = 33'(avg_mag);
            mul_b = 32'(wgt);
         end
         MUL_P: begin
            mul_a = 33'(mag_ff);
            mul_b = kp_ff;
         end
         MUL_I: begin
            mul_a = 33'(integ_ff[20] ? integ_neg : integ_ff);
            mul_b = ki_ff;
         end
         MUL_D: begin
            mul_a = 33'(diff[15] ? diff_neg[14:0] : diff[14:0]);
            mul_b = kd_ff;
         end
         MUL_FHI: begin
            mul_a = xmag_ff[48:16];
            mul_b = 32'(f_eff);
         end
         MUL_FLO: begin
            mul_a = 33'(xmag_ff[15:0]);
            mul_b = 32'(f_eff);
         end
         default: mul_a = '0;
      endcase
   end

   assign mul_prod = 65'(mul_a) * 65'(mul_b);

   // integral, terms, filter, output
   always_comb begin
      q17      = {1'b0, div_quo[15:0]};
      inc      = avg_ff;
      if (band == BAND_MID) begin
         inc = avg_ff[16] ? -q17 : q17;
      end
      s22      = {integ_ff[20], integ_ff} + {{5{inc[16]}}, inc};
      integ_in = integ_ff;
      prior_in = prior_ff;
      if (cmd.integ_ld) begin
         prior_in = e_ff;
         if (band != BAND_STOP) begin
            if (s22 > LimS) begin
               integ_in = LimS[20:0];
            end else if (s22 < -LimS) begin
               integ_in = 21'(-LimS);
            end else begin
               integ_in = s22[20:0];
            end
         end
      end

      pm50   = {10'd0, prod_ff[47:8]};
      im50   = {6'd0, prod_ff[51:8]};
      acc_in = acc_ff;
      if (cmd.acc_p) begin
         acc_in = e_ff[16] ? -pm50 : pm50;
      end else if (cmd.acc_i) begin
         acc_in = acc_ff + (integ_ff[20] ? -im50 : im50);
      end

      d48   = {1'b0, prod_ff[46:0]};
      dm_in = cmd.dm_ld ? (diff[15] ? -d48 : d48) : dm_ff;

      x49     = {dm_ff[47], dm_ff} - {fd_ff[47], fd_ff};
      xneg_in = cmd.x_ld ? x49[48] : xneg_ff;
      xmag_in = cmd.x_ld ? (x49[48] ? -x49 : x49) : xmag_ff;
      hi_in   = cmd.hi_ld ? prod_ff[49:0] : hi_ff;

      r50   = hi_ff + 50'(prod_ff[32:16]);
      fd_in = fd_ff;
      if (cmd.fd_ld) begin
         fd_in = fd_ff + (xneg_ff ? -r50[47:0] : r50[47:0]);
      end

      t_in = cmd.t_ld ? ({acc_ff[49], acc_ff} + {{3{fd_ff[47]}}, fd_ff}) : t_ff;

      lim51        = {20'd0, olim_ff, 16'd0};
      pwm_in       = pwm_ff;
      now_in       = now_ff;
      before_in    = before_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.out_ld) begin
         if (t_ff > lim51) begin
            pwm_in = olim_ff;
         end else if (t_ff[50]) begin
            pwm_in = '0;
         end else begin
            pwm_in = t_ff[30:16];
         end
         before_in    = now_ff;
         now_in       = pwm_in;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      e_ff    <= e_in;
      mag_ff  <= mag_in;
      avg_ff  <= avg_in;
      prod_ff <= mul_prod;
      acc_ff  <= acc_in;
      dm_ff   <= dm_in;
      xmag_ff <= xmag_in;
      xneg_ff <= xneg_in;
      hi_ff   <= hi_in;
      t_ff    <= t_in;
      pwm_ff  <= pwm_in;
      if (reset) begin
         setpoint_ff  <= SetpointReset;
         kp_ff        <= KpReset;
         ki_ff        <= KiReset;
         kd_ff        <= KdReset;
         low_ff       <= LowReset;
         high_ff      <= HighReset;
         filt_ff      <= FiltReset;
         olim_ff      <= OutLimReset;
         prior_ff     <= '0;
         integ_ff     <= '0;
         fd_ff        <= '0;
         now_ff       <= '0;
         before_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         setpoint_ff  <= setpoint_in;
         kp_ff        <= kp_in;
         ki_ff        <= ki_in;
         kd_ff        <= kd_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         filt_ff      <= filt_in;
         olim_ff      <= olim_in;
         prior_ff     <= prior_in;
         integ_ff     <= integ_in;
         fd_ff        <= fd_in;
         now_ff       <= now_in;
         before_ff    <= before_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   phc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (prod_ff[30:0]),
      .divisor  (high_ff - low_ff),
      .busy     (div_busy),
      .quotient (div_quo)
   );

   assign status.band     = band;
   assign status.div_busy = div_busy;
   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign pwm_compare     = pwm_ff;

   `PHC_ASSERT(a_integ_range, (integ_ff <= LimS) && (integ_ff >= -LimS), "integral out of range")
   `PHC_ASSERT_NEXT(a_out_loads_valid, cmd.out_ld, rsp_valid_ff, "result not presented")
endmodule
`default_nettype wire

@@ rtl/core/pid_heater_controller.sv @@
// Top level of the heater PID controller.
//
//   channel   direction  payload                      transfer when
//   req_chan  in         temperature (s16 Q8.8)       valid && ready
//   rsp_chan  out        pwm_compare (u15 counts)     valid && ready
//   csr_*     in         index 0..7, 32-bit data      csr_write_en
//
// When the error lies between the full and stop thresholds, a sample also
// runs the weight multiply and the 31-step divider for the integral weight.
// Products run through one shared 33x32 multiplier, one per cycle.
// A finished result sits in the output register; a stalled result channel
// holds the sequencer in its last state. Synchronous reset restores the
// default registers and clears all loop state.
`default_nettype none
module pid_heater_controller (
   input  logic        clock,
   input  logic        reset,
   phc_req_if.sink     req_chan,
   phc_rsp_if.source   rsp_chan,
   input  logic        csr_write_en,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_write_data
);
   import phc_pkg::*;

   phc_cmd_type    cmd;
   phc_status_type status;
   logic           req_ready;
   logic           rsp_valid;
   logic [14:0]    pwm_compare;

   phc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .status    (status)
   );

   phc_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .temperature    (req_chan.temperature),
      .rsp_ready      (rsp_chan.ready),
      .rsp_valid      (rsp_valid),
      .pwm_compare    (pwm_compare),
      .cmd            (cmd),
      .status         (status)
   );

   assign req_chan.ready       = req_ready;
   assign rsp_chan.valid       = rsp_valid;
   assign rsp_chan.pwm_compare = pwm_compare;
endmodule
`default_nettype wire
